@@ sv/aarm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared constants, types and arithmetic helpers for the axis-angle rotation
// matrix core: stage counts, latencies, fixed-point constants, arctangent table.
// ----------------------------------------------------------------------------
package aarm_pkg;

   // iteration counts of the pipelined units
   localparam int CORDIC_STEPS = 20;
   localparam int SQRT_STEPS   = 31;
   localparam int DIV_STEPS    = 31;

   // unit latencies in register stages
   localparam int CORDIC_LAT   = CORDIC_STEPS + 3;
   localparam int DIV_LAT      = DIV_STEPS + 2;
   localparam int MATRIX_LAT   = 3;

   // stage at which the unit axis leaves the divider (input register is stage 1)
   localparam int UNIT_STAGE   = 3 + SQRT_STEPS + DIV_LAT;
   localparam int MAG_DELAY    = 2 + SQRT_STEPS;
   localparam int ANGLE_DELAY  = UNIT_STAGE - CORDIC_LAT - 1;
   localparam int ZERO_DELAY   = UNIT_STAGE - 3;
   localparam int TOTAL_LAT    = UNIT_STAGE + MATRIX_LAT;

   // fixed-point constants
   localparam logic [34:0]        TURN_K      = 35'd10937044410;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
   localparam logic signed [15:0] ONE_Q14     = 16'sd16384;

   typedef logic signed [33:0] trig_type;
   typedef logic signed [31:0] unit_type;
   typedef logic signed [15:0] q14_type;

   // arctangent of 2^-i as a fraction of a turn, 2^32 per turn
   function automatic logic signed [31:0] atan_turn(input logic [4:0] idx);
      logic signed [31:0] val;
      case (idx)
         5'd0:    val = 32'sh2000_0000;
         5'd1:    val = 32'sh12E4_051E;
         5'd2:    val = 32'sh09FB_385B;
         5'd3:    val = 32'sh0511_11D4;
         5'd4:    val = 32'sh028B_0D43;
         5'd5:    val = 32'sh0145_D7E1;
         5'd6:    val = 32'sh00A2_F61E;
         5'd7:    val = 32'sh0051_7C55;
         5'd8:    val = 32'sh0028_BE53;
         5'd9:    val = 32'sh0014_5F2F;
         5'd10:   val = 32'sh000A_2F98;
         5'd11:   val = 32'sh0005_17CC;
         5'd12:   val = 32'sh0002_8BE6;
         5'd13:   val = 32'sh0001_45F3;
         5'd14:   val = 32'sh0000_A2FA;
         5'd15:   val = 32'sh0000_517D;
         5'd16:   val = 32'sh0000_28BE;
         5'd17:   val = 32'sh0000_145F;
         5'd18:   val = 32'sh0000_0A30;
         5'd19:   val = 32'sh0000_0518;
         default: val = 32'sh0000_0000;
      endcase
      return val;
   endfunction

   // q30 product, rounded half up by floor
   function automatic trig_type mul_q30(input trig_type a, input trig_type b);
      logic signed [67:0] p;
      p = a * b;
      p = p + 68'sh2000_0000;
      return 34'(p >>> 30);
   endfunction

   // q30 sum to q1.14 with rounding and saturation
   function automatic q14_type to_q14(input logic signed [35:0] e);
      logic signed [35:0] r;
      r = (e + 36'sd32768) >>> 16;
      if (r > 36'sd16384) begin
         r = 36'sd16384;
      end else if (r < -36'sd16384) begin
         r = -36'sd16384;
      end
      return 16'(r);
   endfunction

endpackage

@@ sv/aarm_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_cordic
// Angle to cosine and sine: turn scaling, quadrant fold, one rotation-mode
// CORDIC iteration per stage, then quadrant mapping and 1 - cos.
// ----------------------------------------------------------------------------
module aarm_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic signed [16:0]  in_angle,
   output logic                out_valid,
   output aarm_pkg::trig_type  out_cos,
   output aarm_pkg::trig_type  out_sin,
   output aarm_pkg::trig_type  out_cv
);
   import aarm_pkg::*;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   logic [CORDIC_LAT-1:0] valid_ff;
   logic signed [52:0]    prod_in;
   logic [47:0]           prod_ff;
   logic [47:0]           round_sum;
   logic [31:0]           phase;
   logic [31:0]           quad_sum;
   logic [1:0]            quad_in;
   logic [31:0]           resid_in;
   logic [1:0]            quad0_ff;
   logic signed [31:0]    z0_ff;
   trig_type              x_ff [CORDIC_STEPS];
   trig_type              y_ff [CORDIC_STEPS];
   logic signed [31:0]    z_ff [CORDIC_STEPS];
   logic [1:0]            quad_ff [CORDIC_STEPS];
   trig_type              cos_in, sin_in;
   trig_type              cos_ff, sin_ff, cv_ff;

   // valid bits follow the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[CORDIC_LAT-2:0], in_valid};
      end
   end

   // angle times turns per radian
   assign prod_in = in_angle * $signed({1'b0, TURN_K});

   always_ff @(posedge clock) begin
      prod_ff <= prod_in[47:0];
   end

   // round to a 32-bit phase, fold to the nearest quadrant
   assign round_sum = prod_ff + 48'h8000;
   assign phase     = round_sum[47:16];
   assign quad_sum  = phase + 32'h2000_0000;
   assign quad_in   = quad_sum[31:30];
   assign resid_in  = phase - {quad_in, 30'd0};

   always_ff @(posedge clock) begin
      quad0_ff <= quad_in;
      z0_ff    <= $signed(resid_in);
   end

   // rotation iterations, one per stage
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
      trig_type           x_cur, y_cur, x_sh, y_sh;
      logic signed [31:0] z_cur, ang;
      logic [1:0]         q_cur;
      if (k == 0) begin : g_first
         assign x_cur = CORDIC_GAIN;
         assign y_cur = '0;
         assign z_cur = z0_ff;
         assign q_cur = quad0_ff;
      end else begin : g_next
         assign x_cur = x_ff[k-1];
         assign y_cur = y_ff[k-1];
         assign z_cur = z_ff[k-1];
         assign q_cur = quad_ff[k-1];
      end
      assign x_sh = x_cur >>> k;
      assign y_sh = y_cur >>> k;
      assign ang  = atan_turn(5'(k));

      always_ff @(posedge clock) begin
         quad_ff[k] <= q_cur;
         if (z_cur >= 0) begin
            x_ff[k] <= x_cur - y_sh;
            y_ff[k] <= y_cur + x_sh;
            z_ff[k] <= z_cur - ang;
         end else begin
            x_ff[k] <= x_cur + y_sh;
            y_ff[k] <= y_cur - x_sh;
            z_ff[k] <= z_cur + ang;
         end
      end
   end

   // quadrant mapping
   always_comb begin
      case (quad_ff[CORDIC_STEPS-1])
         QUAD_0: begin
            cos_in = x_ff[CORDIC_STEPS-1];
            sin_in = y_ff[CORDIC_STEPS-1];
         end
         QUAD_1: begin
            cos_in = -y_ff[CORDIC_STEPS-1];
            sin_in = x_ff[CORDIC_STEPS-1];
         end
         QUAD_2: begin
            cos_in = -x_ff[CORDIC_STEPS-1];
            sin_in = -y_ff[CORDIC_STEPS-1];
         end
         QUAD_3: begin
            cos_in = y_ff[CORDIC_STEPS-1];
            sin_in = -x_ff[CORDIC_STEPS-1];
         end
         default: begin
            cos_in = x_ff[CORDIC_STEPS-1];
            sin_in = y_ff[CORDIC_STEPS-1];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cos_ff <= cos_in;
      sin_ff <= sin_in;
      cv_ff  <= ONE_Q30 - cos_in;
   end

   assign out_valid = valid_ff[CORDIC_LAT-1];
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_cv    = cv_ff;

endmodule

@@ sv/aarm_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_isqrt
// Pipelined integer square root of the squared axis length scaled by 2^28,
// one result bit per stage.
// ----------------------------------------------------------------------------
module aarm_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_sumsq,
   output logic        out_valid,
   output logic [30:0] out_len
);
   import aarm_pkg::*;

   logic [SQRT_STEPS-1:0] valid_ff;
   logic [61:0]           rem_ff  [SQRT_STEPS];
   logic [61:0]           root_ff [SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[SQRT_STEPS-2:0], in_valid};
      end
   end

   // digit-by-digit root, highest digit first
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [61:0] StepBit = 62'd1 << (2 * (SQRT_STEPS - 1 - k));
      logic [61:0] rem_cur, root_cur, trial;
      if (k == 0) begin : g_first
         assign rem_cur  = {2'b00, in_sumsq, 28'd0};
         assign root_cur = '0;
      end else begin : g_next
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
      end
      assign trial = root_cur + StepBit;

      always_ff @(posedge clock) begin
         if (rem_cur >= trial) begin
            rem_ff[k]  <= rem_cur - trial;
            root_ff[k] <= (root_cur >> 1) + StepBit;
         end else begin
            rem_ff[k]  <= rem_cur;
            root_ff[k] <= root_cur >> 1;
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_len   = root_ff[SQRT_STEPS-1][30:0];

endmodule

@@ sv/aarm_divide.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_divide
// Pipelined restoring divider for one axis component: magnitude times 2^44
// over the axis length, rounded, one quotient bit per stage, sign restored.
// ----------------------------------------------------------------------------
module aarm_divide (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [15:0]        in_mag,
   input  logic               in_neg,
   input  logic [30:0]        in_len,
   output logic               out_valid,
   output aarm_pkg::unit_type out_unit
);
   import aarm_pkg::*;

   logic [DIV_LAT-1:0]   valid_ff;
   logic [61:0]          num_ff;
   logic [30:0]          den0_ff;
   logic                 neg0_ff;
   logic [61:0]          rem_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff [DIV_STEPS];
   logic [30:0]          den_ff [DIV_STEPS];
   logic                 neg_ff [DIV_STEPS];
   unit_type             unit_in;
   unit_type             unit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[DIV_LAT-2:0], in_valid};
      end
   end

   // numerator with half the divisor added for rounding
   always_ff @(posedge clock) begin
      num_ff  <= (62'(in_mag) << 44) + 62'(in_len >> 1);
      den0_ff <= in_len;
      neg0_ff <= in_neg;
   end

   // one quotient bit per stage, highest first
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int Shift = DIV_STEPS - 1 - k;
      logic [61:0]          rem_cur, sub;
      logic [DIV_STEPS-1:0] quo_cur;
      logic [30:0]          den_cur;
      logic                 neg_cur;
      if (k == 0) begin : g_first
         assign rem_cur = num_ff;
         assign quo_cur = '0;
         assign den_cur = den0_ff;
         assign neg_cur = neg0_ff;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign quo_cur = quo_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign neg_cur = neg_ff[k-1];
      end
      assign sub = 62'(den_cur) << Shift;

      always_ff @(posedge clock) begin
         den_ff[k] <= den_cur;
         neg_ff[k] <= neg_cur;
         if (rem_cur >= sub) begin
            rem_ff[k] <= rem_cur - sub;
            quo_ff[k] <= quo_cur | (DIV_STEPS'(1) << Shift);
         end else begin
            rem_ff[k] <= rem_cur;
            quo_ff[k] <= quo_cur;
         end
      end
   end

   // restore the sign
   always_comb begin
      unit_in = $signed({1'b0, quo_ff[DIV_STEPS-1]});
      if (neg_ff[DIV_STEPS-1]) begin
         unit_in = -unit_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
   end

   assign out_valid = valid_ff[DIV_LAT-1];
   assign out_unit  = unit_ff;

endmodule

@@ sv/aarm_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarm_matrix
// Rodrigues element assembly: axis products and sine terms, products with
// 1 - cos, then sums, rounding to q1.14 and identity for a zero axis.
// ----------------------------------------------------------------------------
module aarm_matrix (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_zero,
   input  aarm_pkg::unit_type in_ux,
   input  aarm_pkg::unit_type in_uy,
   input  aarm_pkg::unit_type in_uz,
   input  aarm_pkg::trig_type in_cos,
   input  aarm_pkg::trig_type in_sin,
   input  aarm_pkg::trig_type in_cv,
   output logic               out_valid,
   output logic               out_zero,
   output aarm_pkg::q14_type  out_elem [9]
);
   import aarm_pkg::*;

   logic [MATRIX_LAT-1:0] valid_ff;
   trig_type ux, uy, uz;

   // stage one: axis products and sine terms
   trig_type xx_ff, xy_ff, xz_ff, yy_ff, yz_ff, zz_ff;
   trig_type xs1_ff, ys1_ff, zs1_ff;
   trig_type cos1_ff, cv1_ff;
   logic     zero1_ff;

   // stage two: products with 1 - cos
   trig_type xxc_ff, xyc_ff, xzc_ff, yyc_ff, yzc_ff, zzc_ff;
   trig_type xs2_ff, ys2_ff, zs2_ff, cos2_ff;
   logic     zero2_ff;

   // stage three: output elements
   logic signed [35:0] e_in [9];
   q14_type            elem_in [9];
   q14_type            elem_ff [9];
   logic               zero3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[MATRIX_LAT-2:0], in_valid};
      end
   end

   assign ux = 34'(in_ux);
   assign uy = 34'(in_uy);
   assign uz = 34'(in_uz);

   always_ff @(posedge clock) begin
      xx_ff    <= mul_q30(ux, ux);
      xy_ff    <= mul_q30(ux, uy);
      xz_ff    <= mul_q30(ux, uz);
      yy_ff    <= mul_q30(uy, uy);
      yz_ff    <= mul_q30(uy, uz);
      zz_ff    <= mul_q30(uz, uz);
      xs1_ff   <= mul_q30(ux, in_sin);
      ys1_ff   <= mul_q30(uy, in_sin);
      zs1_ff   <= mul_q30(uz, in_sin);
      cos1_ff  <= in_cos;
      cv1_ff   <= in_cv;
      zero1_ff <= in_zero;
   end

   always_ff @(posedge clock) begin
      xxc_ff   <= mul_q30(xx_ff, cv1_ff);
      xyc_ff   <= mul_q30(xy_ff, cv1_ff);
      xzc_ff   <= mul_q30(xz_ff, cv1_ff);
      yyc_ff   <= mul_q30(yy_ff, cv1_ff);
      yzc_ff   <= mul_q30(yz_ff, cv1_ff);
      zzc_ff   <= mul_q30(zz_ff, cv1_ff);
      xs2_ff   <= xs1_ff;
      ys2_ff   <= ys1_ff;
      zs2_ff   <= zs1_ff;
      cos2_ff  <= cos1_ff;
      zero2_ff <= zero1_ff;
   end

   // row by row sums
   assign e_in[0] = 36'(xxc_ff) + 36'(cos2_ff);
   assign e_in[1] = 36'(xyc_ff) + 36'(zs2_ff);
   assign e_in[2] = 36'(xzc_ff) - 36'(ys2_ff);
   assign e_in[3] = 36'(xyc_ff) - 36'(zs2_ff);
   assign e_in[4] = 36'(yyc_ff) + 36'(cos2_ff);
   assign e_in[5] = 36'(yzc_ff) + 36'(xs2_ff);
   assign e_in[6] = 36'(xzc_ff) + 36'(ys2_ff);
   assign e_in[7] = 36'(yzc_ff) - 36'(xs2_ff);
   assign e_in[8] = 36'(zzc_ff) + 36'(cos2_ff);

   // rounding, saturation and identity for a zero axis
   for (genvar j = 0; j < 9; j++) begin : g_elem
      always_comb begin
         if (zero2_ff) begin
            elem_in[j] = (j % 4 == 0) ? ONE_Q14 : '0;
         end else begin
            elem_in[j] = to_q14(e_in[j]);
         end
      end

      always_ff @(posedge clock) begin
         elem_ff[j] <= elem_in[j];
      end

      assign out_elem[j] = elem_ff[j];
   end

   always_ff @(posedge clock) begin
      zero3_ff <= zero2_ff;
   end

   assign out_valid = valid_ff[MATRIX_LAT-1];
   assign out_zero  = zero3_ff;

endmodule

@@ sv/axis_angle_rotation_matrix_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_core
// 3x3 rotation block from an angle and an axis of any length: axis squared
// length, square root and divide for the unit axis, CORDIC for sine and cosine,
// then the Rodrigues elements in q1.14.
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------------------------
//   request  | start / busy     | req_angle, req_axis_x/y/z, req_reverse
//   response | rsp_valid strobe | rsp_m00 .. rsp_m22, rsp_zero_axis
//
// One request per cycle is taken. The latency is set by the square root
// (31 stages) followed by the divider (33 stages); the CORDIC runs alongside
// on a delayed angle.
// busy is high only during reset; synchronous reset clears all valid bits.
// The response side has no backpressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [15:0]  req_angle,
   input  logic signed [15:0]  req_axis_x,
   input  logic signed [15:0]  req_axis_y,
   input  logic signed [15:0]  req_axis_z,
   input  logic                req_reverse,
   output logic                rsp_valid,
   output aarm_pkg::q14_type   rsp_m00,
   output aarm_pkg::q14_type   rsp_m01,
   output aarm_pkg::q14_type   rsp_m02,
   output aarm_pkg::q14_type   rsp_m10,
   output aarm_pkg::q14_type   rsp_m11,
   output aarm_pkg::q14_type   rsp_m12,
   output aarm_pkg::q14_type   rsp_m20,
   output aarm_pkg::q14_type   rsp_m21,
   output aarm_pkg::q14_type   rsp_m22,
   output logic                rsp_zero_axis
);
   import aarm_pkg::*;

   logic               accept;
   logic               s1_valid_ff;
   logic signed [16:0] angle_in;
   logic signed [16:0] s1_angle_ff;
   logic signed [15:0] s1_x_ff, s1_y_ff, s1_z_ff;
   logic [16:0]        mag_x_in, mag_y_in, mag_z_in;
   logic               s2_valid_ff;
   logic signed [31:0] sq_x_in, sq_y_in, sq_z_in;
   logic [31:0]        sq_x_ff, sq_y_ff, sq_z_ff;
   logic               s3_valid_ff;
   logic [31:0]        sumsq_ff;
   logic               zero_ff;

   logic [50:0]            mag_dly_ff   [MAG_DELAY];
   logic signed [16:0]     angle_dly_ff [ANGLE_DELAY];
   logic [ANGLE_DELAY-1:0] angle_vld_ff;
   logic [ZERO_DELAY-1:0]  zero_dly_ff;

   logic       len_valid;
   logic [30:0] len;
   logic [50:0] mag_dly;
   logic       ux_valid, uy_valid, uz_valid;
   unit_type   ux, uy, uz;
   logic       trig_valid;
   trig_type   cos_v, sin_v, cv_v;
   q14_type    elem [9];

   // request taken whenever not in reset
   assign busy   = reset;
   assign accept = start & ~busy;

   // input register with optional angle negation, one bit wider
   assign angle_in = req_reverse ? -17'(req_angle) : 17'(req_angle);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_angle_ff <= angle_in;
      s1_x_ff     <= req_axis_x;
      s1_y_ff     <= req_axis_y;
      s1_z_ff     <= req_axis_z;
   end

   // squares of the axis components
   assign sq_x_in = s1_x_ff * s1_x_ff;
   assign sq_y_in = s1_y_ff * s1_y_ff;
   assign sq_z_in = s1_z_ff * s1_z_ff;

   always_ff @(posedge clock) begin
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      sq_z_ff <= sq_z_in;
   end

   // squared length and zero-axis flag
   always_ff @(posedge clock) begin
      sumsq_ff <= sq_x_ff + sq_y_ff + sq_z_ff;
      zero_ff  <= (sq_x_ff == '0) && (sq_y_ff == '0) && (sq_z_ff == '0);
   end

   aarm_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_sumsq  (sumsq_ff),
      .out_valid (len_valid),
      .out_len   (len)
   );

   // sign and magnitude of each component, delayed to meet the root
   assign mag_x_in = {s1_x_ff[15], s1_x_ff[15] ? 16'(-s1_x_ff) : 16'(s1_x_ff)};
   assign mag_y_in = {s1_y_ff[15], s1_y_ff[15] ? 16'(-s1_y_ff) : 16'(s1_y_ff)};
   assign mag_z_in = {s1_z_ff[15], s1_z_ff[15] ? 16'(-s1_z_ff) : 16'(s1_z_ff)};

   always_ff @(posedge clock) begin
      mag_dly_ff[0] <= {mag_x_in, mag_y_in, mag_z_in};
      for (int i = 1; i < MAG_DELAY; i++) begin
         mag_dly_ff[i] <= mag_dly_ff[i-1];
      end
   end

   assign mag_dly = mag_dly_ff[MAG_DELAY-1];

   aarm_divide u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (len_valid),
      .in_mag    (mag_dly[49:34]),
      .in_neg    (mag_dly[50]),
      .in_len    (len),
      .out_valid (ux_valid),
      .out_unit  (ux)
   );

   aarm_divide u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (len_valid),
      .in_mag    (mag_dly[32:17]),
      .in_neg    (mag_dly[33]),
      .in_len    (len),
      .out_valid (uy_valid),
      .out_unit  (uy)
   );

   aarm_divide u_div_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (len_valid),
      .in_mag    (mag_dly[15:0]),
      .in_neg    (mag_dly[16]),
      .in_len    (len),
      .out_valid (uz_valid),
      .out_unit  (uz)
   );

   // angle delayed so that sine and cosine meet the unit axis
   always_ff @(posedge clock) begin
      angle_dly_ff[0] <= s1_angle_ff;
      for (int i = 1; i < ANGLE_DELAY; i++) begin
         angle_dly_ff[i] <= angle_dly_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_vld_ff <= '0;
         zero_dly_ff  <= '0;
      end else begin
         angle_vld_ff <= {angle_vld_ff[ANGLE_DELAY-2:0], s1_valid_ff};
         zero_dly_ff  <= {zero_dly_ff[ZERO_DELAY-2:0], zero_ff};
      end
   end

   aarm_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (angle_vld_ff[ANGLE_DELAY-1]),
      .in_angle  (angle_dly_ff[ANGLE_DELAY-1]),
      .out_valid (trig_valid),
      .out_cos   (cos_v),
      .out_sin   (sin_v),
      .out_cv    (cv_v)
   );

   aarm_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ux_valid),
      .in_zero   (zero_dly_ff[ZERO_DELAY-1]),
      .in_ux     (ux),
      .in_uy     (uy),
      .in_uz     (uz),
      .in_cos    (cos_v),
      .in_sin    (sin_v),
      .in_cv     (cv_v),
      .out_valid (rsp_valid),
      .out_zero  (rsp_zero_axis),
      .out_elem  (elem)
   );

   assign rsp_m00 = elem[0];
   assign rsp_m01 = elem[1];
   assign rsp_m02 = elem[2];
   assign rsp_m10 = elem[3];
   assign rsp_m11 = elem[4];
   assign rsp_m12 = elem[5];
   assign rsp_m20 = elem[6];
   assign rsp_m21 = elem[7];
   assign rsp_m22 = elem[8];

   // trig path and axis path stay in step
   a_trig_align: assert property (@(posedge clock) disable iff (reset)
      (trig_valid == ux_valid) && (uy_valid == ux_valid) && (uz_valid == ux_valid))
      else $error("trig and unit axis out of step");

   // every result traces back to a request taken at fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, TOTAL_LAT))
      else $error("result without matching request");

   // diagonal elements stay within plus and minus one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_m00 <= ONE_Q14) && (rsp_m00 >= -ONE_Q14)
                 && (rsp_m11 <= ONE_Q14) && (rsp_m11 >= -ONE_Q14)
                 && (rsp_m22 <= ONE_Q14) && (rsp_m22 >= -ONE_Q14))
      else $error("diagonal element out of range");

endmodule
